### rtl/oamdma_pkg.sv
// Shared types and constants for the sprite and sample DMA cycle arbiter.
package oamdma_pkg;

    // Function codes carried by an input transfer.
    localparam logic [1:0] FUNC_BUS    = 2'd0;
    localparam logic [1:0] FUNC_SPRITE = 2'd1;
    localparam logic [1:0] FUNC_SAMPLE = 2'd2;

    // Sprite copy length in bus cycles (one read and one write per byte).
    localparam int SPRITE_CYCLES = 512;
    localparam int CNT_W         = 10;

    // Fixed addresses.
    localparam logic [15:0] ADDR_OAM_DATA = 16'h2004;
    localparam logic [15:0] ADDR_JOY1     = 16'h4016;
    localparam logic [15:0] ADDR_JOY2     = 16'h4017;

    typedef enum logic [2:0] {
        KIND_CPU    = 3'd0,
        KIND_HALT   = 3'd1,
        KIND_DUMMY  = 3'd2,
        KIND_IDLE   = 3'd3,
        KIND_SAMPLE = 3'd4,
        KIND_SPR_RD = 3'd5,
        KIND_SPR_WR = 3'd6
    } t_kind;

    typedef struct packed {
        logic [1:0]  func;
        logic        cpu_reads;
        logic [15:0] cpu_addr;
        logic [7:0]  sprite_page;
        logic [15:0] sample_addr;
        logic [7:0]  bus_read_data;
    } t_in_item;

    typedef struct packed {
        t_kind       access_kind;
        logic [15:0] bus_addr;
        logic [7:0]  bus_write_data;
        logic        bus_writes;
        logic        cpu_stalled;
    } t_out_item;

    typedef struct packed {
        logic             cycle_parity;
        logic             sprite_active;
        logic [7:0]       sprite_page_reg;
        logic [7:0]       sprite_read_index;
        logic [CNT_W-1:0] sprite_cycle_count;
        logic             sample_active;
        logic [15:0]      sample_addr_reg;
        logic             halt_pending;
        logic             dummy_pending;
        logic             in_dma;
        logic [15:0]      held_cpu_addr;
        logic [7:0]       byte_latch;
        logic             latch_pending;
    } t_state;

endpackage

### rtl/oam_and_sample_dma_cycle_arbiter.sv
// Top level of the sprite copy and sample fetch DMA cycle arbiter.
//
//   Channel   Signals                                Direction  Contents
//   input     i_in_valid, o_in_ready, i_in_data      in         t_in_item
//   output    o_out_valid, i_out_ready, o_out_data   out        t_out_item
//
// Each input transfer is one CPU bus cycle or a start command, and a new one
// can be taken on every clock unless the output stalls: the decision logic
// sits between the input ports and a single result register.
// Start commands update state but make no result; the unused function code
// is taken and dropped, leaving state unchanged.
// Reset is synchronous and active low; it clears all DMA state to zero.
// A stalled output only blocks the input when the result register is full
// and not being taken in the same cycle.
module oam_and_sample_dma_cycle_arbiter
    import oamdma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // Architectural DMA state, updated once per accepted input transfer.
    t_state    r_state;
    t_state    n_state;
    // Result register toward the output channel.
    logic      r_out_valid;
    t_out_item r_out_data;

    t_out_item step_result;
    logic      step_has_result;
    logic      in_accept;

    // The input side is free whenever the result register is empty or is
    // being drained in this very cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    oamdma_step u_step (
        .i_state      (r_state),
        .i_item       (i_in_data),
        .o_state      (n_state),
        .o_result     (step_result),
        .o_has_result (step_has_result)
    );

    // The state only advances when a transfer is actually accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // The output valid flag is set by a transfer that makes a result and is
    // cleared once the held result has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && step_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (in_accept && step_has_result) begin
            r_out_data <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/oamdma_step.sv
// Next-state and bus-cycle decision logic for one input transfer.
module oamdma_step
    import oamdma_pkg::*;
(
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result,
    output logic      o_has_result
);

    t_out_item        dummy_res;
    logic [7:0]       latch_val;
    logic [CNT_W-1:0] cnt_inc;
    logic             held_is_joy;

    // A dummy slot at a controller port is turned into an idle cycle.
    assign held_is_joy = (i_state.held_cpu_addr == ADDR_JOY1) ||
                         (i_state.held_cpu_addr == ADDR_JOY2);
    assign latch_val   = i_state.latch_pending ? i_item.bus_read_data : i_state.byte_latch;
    assign cnt_inc     = i_state.sprite_cycle_count + CNT_W'(1);

    always_comb begin
        dummy_res = '0;
        dummy_res.cpu_stalled = 1'b1;
        if (held_is_joy) begin
            dummy_res.access_kind = KIND_IDLE;
        end else begin
            dummy_res.access_kind = KIND_DUMMY;
            dummy_res.bus_addr    = i_state.held_cpu_addr;
        end
    end

    always_comb begin
        o_state      = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        priority if (i_item.func == FUNC_SPRITE) begin
            o_state.sprite_active      = 1'b1;
            o_state.sprite_page_reg    = i_item.sprite_page;
            o_state.sprite_read_index  = '0;
            o_state.sprite_cycle_count = '0;
            o_state.halt_pending       = 1'b1;
        end else if (i_item.func == FUNC_SAMPLE) begin
            o_state.sample_active   = 1'b1;
            o_state.sample_addr_reg = i_item.sample_addr;
            o_state.dummy_pending   = 1'b1;
            o_state.halt_pending    = 1'b1;
        end else if (i_item.func == FUNC_BUS) begin
            o_has_result          = 1'b1;
            o_state.byte_latch    = latch_val;
            o_state.latch_pending = 1'b0;
            o_state.cycle_parity  = ~i_state.cycle_parity;
            if (!i_state.in_dma) begin
                if (i_state.halt_pending && i_item.cpu_reads) begin
                    o_result.access_kind       = KIND_HALT;
                    o_result.bus_addr          = i_item.cpu_addr;
                    o_result.cpu_stalled       = 1'b1;
                    o_state.halt_pending       = 1'b0;
                    o_state.held_cpu_addr      = i_item.cpu_addr;
                    o_state.sprite_read_index  = '0;
                    o_state.sprite_cycle_count = '0;
                    o_state.in_dma = i_state.sprite_active || i_state.sample_active;
                end else begin
                    o_result.access_kind = KIND_CPU;
                    o_result.bus_addr    = i_item.cpu_addr;
                    o_result.bus_writes  = ~i_item.cpu_reads;
                end
            end else begin
                // Each DMA cycle retires at most one pending slot: a halt slot first, else a dummy slot.
                if (i_state.halt_pending) begin
                    o_state.halt_pending = 1'b0;
                end else if (i_state.dummy_pending) begin
                    o_state.dummy_pending = 1'b0;
                end
                if (!i_state.cycle_parity) begin
                    if (i_state.sample_active && !i_state.halt_pending &&
                        !i_state.dummy_pending) begin
                        o_result.access_kind  = KIND_SAMPLE;
                        o_result.bus_addr     = i_state.sample_addr_reg;
                        o_result.cpu_stalled  = 1'b1;
                        o_state.sample_active = 1'b0;
                    end else if (i_state.sprite_active) begin
                        o_result.access_kind       = KIND_SPR_RD;
                        o_result.bus_addr          = {i_state.sprite_page_reg,
                                                      i_state.sprite_read_index};
                        o_result.cpu_stalled       = 1'b1;
                        o_state.sprite_read_index  = i_state.sprite_read_index + 8'd1;
                        o_state.sprite_cycle_count = cnt_inc;
                        o_state.latch_pending      = 1'b1;
                    end else begin
                        o_result = dummy_res;
                    end
                end else begin
                    if (i_state.sprite_active && i_state.sprite_cycle_count[0]) begin
                        o_result.access_kind       = KIND_SPR_WR;
                        o_result.bus_addr          = ADDR_OAM_DATA;
                        o_result.bus_write_data    = latch_val;
                        o_result.bus_writes        = 1'b1;
                        o_result.cpu_stalled       = 1'b1;
                        o_state.sprite_cycle_count = cnt_inc;
                        if (cnt_inc >= CNT_W'(SPRITE_CYCLES)) begin
                            o_state.sprite_active = 1'b0;
                        end
                    end else begin
                        o_result = dummy_res;
                    end
                end
                if (!o_state.sprite_active && !o_state.sample_active) begin
                    o_state.in_dma = 1'b0;
                end
            end
        end else begin
            o_has_result = 1'b0;
        end
    end

endmodule
